// ===== src/pms_pkg.sv =====
// Shared types and constants of the periodic message scheduler.
package pms_pkg;

	// Item kinds carried in the slave-side tuser.
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_RESET = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	// Period mode register codes; the unused code behaves as smooth.
	localparam logic [1:0] MODE_SMOOTH   = 2'd0;
	localparam logic [1:0] MODE_STANDARD = 2'd1;
	localparam logic [1:0] MODE_STRESS   = 2'd2;

	localparam int IN_DATA_W  = 160;
	localparam int OUT_DATA_W = 40;
	localparam int SLOT_W     = 4;

	// One input item as held by the datapath.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now_ms;
		logic [18:0] signal_number;
		logic [17:0] group_number;
		logic [31:0] timeframe;
		logic [15:0] standard_period;
		logic [15:0] stress_period;
		logic [15:0] smooth_period;
		logic [2:0]  priority_req;
		logic [7:0]  src_addr;
	} pms_item_t;

	// Fields of a group entry that are fixed when the group is created.
	typedef struct packed {
		logic [17:0] id;
		logic [15:0] std_period;
		logic [15:0] stress_period;
		logic [15:0] smooth_period;
		logic [2:0]  prio;
		logic [7:0]  source;
	} pms_gstat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic clr_idx;
		logic sig_adv;
		logic sig_append;
		logic grp_adv;
		logic grp_create;
		logic grp_tighten;
		logic tick_hit;
		logic rst_wr;
		logic clr_counts;
		logic push_end;
		logic end_ok;
	} pms_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] kind;
		logic       sig_end;
		logic       sig_full;
		logic       sig_hit;
		logic       grp_end;
		logic       grp_full;
		logic       grp_hit;
		logic       tick_due;
		logic       pend_valid;
		logic       out_free;
	} pms_stat_t;

endpackage

// ===== src/periodic_message_scheduler.sv =====
// Periodic message scheduler: stream interface around controller and datapath.
// Throughput: one item at a time; the next transaction is taken in the cycle after the final
// result enters the output register. Each table scan reads one slot per cycle, except that
// a tick scan waits on a due group while the pending one cannot move into a busy output.
// Reset: arst_n clears fill counts, period mode and control state; tables are not cleared.
module periodic_message_scheduler import pms_pkg::*; #(
	parameter int MAX_GROUPS  = 16,
	parameter int MAX_SIGNALS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [1:0]            cfg_wdata,   // period_mode
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// now_ms[31:0], signal_number[50:32], group_number[68:51], timeframe[100:69],
	// standard_period[116:101], stress_period[132:117], smooth_period[148:133],
	// priority_req[151:149], src_addr[159:152]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,     // kind[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// due_group[17:0], due_priority[20:18], due_source[28:21], due_slot[32:29], zeros above
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,     // ok[0], due[1]
	output logic                  m_tlast
);

	pms_cmd_t  cmd;
	pms_stat_t stat;

	pms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pms_datapath #(
		.MAX_GROUPS  (MAX_GROUPS),
		.MAX_SIGNALS (MAX_SIGNALS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== src/pms_datapath.sv =====
// Datapath of the scheduler: input register, signal and group tables, scan counters, output.
module pms_datapath import pms_pkg::*; #(
	parameter int MAX_GROUPS  = 16,
	parameter int MAX_SIGNALS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  cfg_wen,
	input  logic [1:0]            cfg_wdata,
	input  pms_cmd_t              cmd,
	output pms_stat_t             stat,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);

	localparam int GCW = $clog2(MAX_GROUPS + 1);
	localparam int SCW = $clog2(MAX_SIGNALS + 1);
	localparam int GAW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int SAW = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1;
	localparam logic [GCW-1:0] GRP_MAX = GCW'(MAX_GROUPS);
	localparam logic [SCW-1:0] SIG_MAX = SCW'(MAX_SIGNALS);

	pms_item_t        item_q;
	logic [1:0]       mode_q;
	logic [GCW-1:0]   gcount_q;
	logic [SCW-1:0]   scount_q;
	logic [GCW-1:0]   gidx_q;
	logic [GCW-1:0]   gidx_d;
	logic [SCW-1:0]   sidx_q;
	logic [SCW-1:0]   sidx_d;
	logic [GAW-1:0]   grd_addr;
	logic [SAW-1:0]   srd_addr;
	logic [GAW-1:0]   gwr_addr;
	logic [SAW-1:0]   swr_addr;

	// Table storage.
	pms_gstat_t       gstat_mem [MAX_GROUPS];
	logic [31:0]      gcust_mem [MAX_GROUPS];
	logic [31:0]      glast_mem [MAX_GROUPS];
	logic [18:0]      sig_mem   [MAX_SIGNALS];
	pms_gstat_t       gstat_rd_q;
	logic [31:0]      gcust_rd_q;
	logic [31:0]      glast_rd_q;
	logic [18:0]      sig_rd_q;

	logic             gstat_we;
	logic             gcust_we;
	logic             glast_we;
	pms_gstat_t       gstat_wd;
	logic [31:0]      gcust_wd;
	logic [31:0]      glast_wd;

	logic [31:0]      period;
	logic [31:0]      elapsed;
	logic             tighten_ok;
	logic [GCW+SLOT_W-1:0] slot_ext;
	logic [SLOT_W-1:0] cur_slot;

	// Pending due group of a tick and the output register.
	logic             pend_valid_q;
	logic [17:0]      pend_group_q;
	logic [2:0]       pend_pri_q;
	logic [7:0]       pend_src_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic             out_valid_q;
	logic             out_ok_q;
	logic             out_due_q;
	logic [17:0]      out_group_q;
	logic [2:0]       out_pri_q;
	logic [7:0]       out_src_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic             out_last_q;
	logic             out_free;
	logic             push_pend;
	logic             push_any;

	// Input register, loaded when the controller takes a transaction.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_q.kind            <= s_tuser;
			item_q.now_ms          <= s_tdata[31:0];
			item_q.signal_number   <= s_tdata[50:32];
			item_q.group_number    <= s_tdata[68:51];
			item_q.timeframe       <= s_tdata[100:69];
			item_q.standard_period <= s_tdata[116:101];
			item_q.stress_period   <= s_tdata[132:117];
			item_q.smooth_period   <= s_tdata[148:133];
			item_q.priority_req    <= s_tdata[151:149];
			item_q.src_addr        <= s_tdata[159:152];
		end
	end

	// Period mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SMOOTH;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	// Next scan indexes; the tables are read at the next index so that the
	// registered read data always belongs to the current index.
	always_comb begin
		gidx_d = gidx_q;
		sidx_d = sidx_q;
		if (cmd.clr_idx) begin
			gidx_d = '0;
			sidx_d = '0;
		end else begin
			if (cmd.grp_adv || cmd.tick_hit || cmd.rst_wr) begin
				gidx_d = gidx_q + GCW'(1);
			end
			if (cmd.sig_adv) begin
				sidx_d = sidx_q + SCW'(1);
			end
		end
	end

	assign grd_addr = (gidx_d < GRP_MAX) ? gidx_d[GAW-1:0] : '0;
	assign srd_addr = (sidx_d < SIG_MAX) ? sidx_d[SAW-1:0] : '0;
	assign gwr_addr = (gidx_q < GRP_MAX) ? gidx_q[GAW-1:0] : '0;
	assign swr_addr = (sidx_q < SIG_MAX) ? sidx_q[SAW-1:0] : '0;

	// Scan counters and table fill counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gidx_q   <= '0;
			sidx_q   <= '0;
			gcount_q <= '0;
			scount_q <= '0;
		end else begin
			gidx_q <= gidx_d;
			sidx_q <= sidx_d;
			if (cmd.clr_counts) begin
				gcount_q <= '0;
				scount_q <= '0;
			end else begin
				if (cmd.grp_create) begin
					gcount_q <= gcount_q + GCW'(1);
				end
				if (cmd.sig_append) begin
					scount_q <= scount_q + SCW'(1);
				end
			end
		end
	end

	// Write data of the group tables.
	always_comb begin
		gstat_we               = cmd.grp_create;
		gstat_wd.id            = item_q.group_number;
		gstat_wd.std_period    = item_q.standard_period;
		gstat_wd.stress_period = item_q.stress_period;
		gstat_wd.smooth_period = item_q.smooth_period;
		gstat_wd.prio          = item_q.priority_req;
		gstat_wd.source        = item_q.src_addr;
		gcust_we               = cmd.grp_create || (cmd.grp_tighten && tighten_ok);
		gcust_wd               = item_q.timeframe;
		glast_we               = cmd.grp_create || cmd.tick_hit || cmd.rst_wr;
		glast_wd               = item_q.now_ms;
	end

	// Group tables: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (gstat_we) begin
			gstat_mem[gwr_addr] <= gstat_wd;
		end
		gstat_rd_q <= gstat_mem[grd_addr];
	end

	always_ff @(posedge clk) begin
		if (gcust_we) begin
			gcust_mem[gwr_addr] <= gcust_wd;
		end
		gcust_rd_q <= gcust_mem[grd_addr];
	end

	always_ff @(posedge clk) begin
		if (glast_we) begin
			glast_mem[gwr_addr] <= glast_wd;
		end
		glast_rd_q <= glast_mem[grd_addr];
	end

	// Signal table.
	always_ff @(posedge clk) begin
		if (cmd.sig_append) begin
			sig_mem[swr_addr] <= item_q.signal_number;
		end
		sig_rd_q <= sig_mem[srd_addr];
	end

	// Period in use and due test of the current group.
	always_comb begin
		if (gcust_rd_q != 32'd0) begin
			period = gcust_rd_q;
		end else begin
			unique case (mode_q)
				MODE_STANDARD: period = {16'd0, gstat_rd_q.std_period};
				MODE_STRESS:   period = {16'd0, gstat_rd_q.stress_period};
				default:       period = {16'd0, gstat_rd_q.smooth_period};
			endcase
		end
	end

	assign elapsed    = item_q.now_ms - glast_rd_q;
	assign tighten_ok = (item_q.timeframe != 32'd0) &&
	                    ((gcust_rd_q == 32'd0) || (item_q.timeframe < gcust_rd_q));
	assign slot_ext   = {{SLOT_W{1'b0}}, gidx_q};
	assign cur_slot   = slot_ext[SLOT_W-1:0];

	// Status toward the controller.
	assign out_free = !out_valid_q || m_tready;
	always_comb begin
		stat.kind       = item_q.kind;
		stat.sig_end    = (sidx_q == scount_q);
		stat.sig_full   = (scount_q >= SIG_MAX);
		stat.sig_hit    = (sig_rd_q == item_q.signal_number);
		stat.grp_end    = (gidx_q == gcount_q);
		stat.grp_full   = (gcount_q >= GRP_MAX);
		stat.grp_hit    = (gstat_rd_q.id == item_q.group_number);
		stat.tick_due   = (elapsed >= period);
		stat.pend_valid = pend_valid_q;
		stat.out_free   = out_free;
	end

	// A newly found due group displaces the pending one into the output.
	assign push_pend = cmd.tick_hit && pend_valid_q;
	assign push_any  = push_pend || cmd.push_end;

	// Pending due group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.tick_hit) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.push_end) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_hit) begin
			pend_group_q <= gstat_rd_q.id;
			pend_pri_q   <= gstat_rd_q.prio;
			pend_src_q   <= gstat_rd_q.source;
			pend_slot_q  <= cur_slot;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_any) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_any) begin
			if (pend_valid_q) begin
				out_ok_q    <= 1'b1;
				out_due_q   <= 1'b1;
				out_group_q <= pend_group_q;
				out_pri_q   <= pend_pri_q;
				out_src_q   <= pend_src_q;
				out_slot_q  <= pend_slot_q;
			end else begin
				out_ok_q    <= cmd.end_ok;
				out_due_q   <= 1'b0;
				out_group_q <= '0;
				out_pri_q   <= '0;
				out_src_q   <= '0;
				out_slot_q  <= '0;
			end
			out_last_q <= cmd.push_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - 33){1'b0}}, out_slot_q, out_src_q, out_pri_q, out_group_q};
	assign m_tuser  = {out_due_q, out_ok_q};
	assign m_tlast  = out_last_q;

	// Scan indexes never run past the fill counts.
	a_gidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gidx_q <= gcount_q) else $error("group scan index beyond group count");
	a_sidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sidx_q <= scount_q) else $error("signal scan index beyond signal count");
	a_gcount_max: assert property (@(posedge clk) disable iff (!arst_n)
		gcount_q <= GRP_MAX) else $error("group count above table size");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push_any |-> out_free) else $error("result pushed into a full output register");

endmodule

// ===== src/pms_ctrl.sv =====
// Controller state machine of the scheduler: sequences table scans and result pushes.
module pms_ctrl import pms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  pms_stat_t stat,
	output pms_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_TICK = 3'd2;
	localparam logic [2:0] S_TEND = 3'd3;
	localparam logic [2:0] S_SIG  = 3'd4;
	localparam logic [2:0] S_GRP  = 3'd5;
	localparam logic [2:0] S_RST  = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       ok_q;
	logic       ok_d;

	assign s_tready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		cmd     = '0;
		cmd.end_ok = ok_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					cmd.clr_idx = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.kind)
					KIND_TICK:  state_d = S_TICK;
					KIND_ADD:   state_d = S_SIG;
					KIND_RESET: state_d = S_RST;
					KIND_CLEAR: begin
						cmd.clr_counts = 1'b1;
						ok_d           = 1'b1;
						state_d        = S_RESP;
					end
				endcase
			end
			S_TICK: begin
				priority if (stat.grp_end) begin
					state_d = S_TEND;
				end else if (!stat.tick_due) begin
					cmd.grp_adv = 1'b1;
				end else if (!stat.pend_valid || stat.out_free) begin
					cmd.tick_hit = 1'b1;
				end
			end
			S_TEND: begin
				if (stat.out_free) begin
					cmd.push_end = 1'b1;
					cmd.end_ok   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SIG: begin
				priority if (stat.sig_end) begin
					if (stat.sig_full) begin
						ok_d    = 1'b0;
						state_d = S_RESP;
					end else begin
						cmd.sig_append = 1'b1;
						state_d        = S_GRP;
					end
				end else if (stat.sig_hit) begin
					state_d = S_GRP;
				end else begin
					cmd.sig_adv = 1'b1;
				end
			end
			S_GRP: begin
				priority if (stat.grp_end) begin
					if (stat.grp_full) begin
						ok_d = 1'b0;
					end else begin
						cmd.grp_create = 1'b1;
						ok_d           = 1'b1;
					end
					state_d = S_RESP;
				end else if (stat.grp_hit) begin
					cmd.grp_tighten = 1'b1;
					ok_d            = 1'b1;
					state_d         = S_RESP;
				end else begin
					cmd.grp_adv = 1'b1;
				end
			end
			S_RST: begin
				if (stat.grp_end) begin
					ok_d    = 1'b1;
					state_d = S_RESP;
				end else begin
					cmd.rst_wr = 1'b1;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.push_end = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

	// State and result flag registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q    <= 1'b1;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
		end
	end

	// A pending due group exists only while a tick is being scanned.
	a_pend_tick: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pend_valid |-> (state_q == S_TICK || state_q == S_TEND))
		else $error("pending due group outside a tick");
	// The final result of an item returns the controller to idle.
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_end |=> s_tready) else $error("not idle after final result");
	// No input is taken while another item is in work.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> !s_tready) else $error("controller stayed idle after taking an item");

endmodule

// ===== bench/periodic_message_scheduler_tb.sv =====
// Self-checking testbench for the periodic message scheduler stream block.
module periodic_message_scheduler_tb;
	import pms_pkg::*;

	localparam int MAX_G = 16;
	localparam int MAX_S = 32;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// One result transaction as seen on the master side.
	typedef struct packed {
		logic        ok;
		logic        due;
		logic [17:0] grp;
		logic [2:0]  prio;
		logic [7:0]  src;
		logic [3:0]  slot;
		logic        last;
	} send_t;

	// Shadow of the group and signal tables, and the sends they are expected to cause.
	class sched_scoreboard;
		logic [17:0] g_id [MAX_G];
		logic [15:0] g_std [MAX_G];
		logic [15:0] g_stress [MAX_G];
		logic [15:0] g_smooth [MAX_G];
		logic [2:0]  g_prio [MAX_G];
		logic [7:0]  g_src [MAX_G];
		logic [31:0] g_custom [MAX_G];
		logic [31:0] g_sent [MAX_G];
		logic [18:0] s_id [MAX_S];
		logic [17:0] s_grp [MAX_S];
		int unsigned g_count;
		int unsigned s_count;
		logic [1:0]  mode;
		send_t       awaited_sends[$];
		int unsigned errors;
		int unsigned kinds_seen [4];
		int unsigned refusals;
		int unsigned checked;
		int unsigned group_sends;

		function new();
			g_count = 0;
			s_count = 0;
			mode = MODE_SMOOTH;
			errors = 0;
			refusals = 0;
			checked = 0;
			group_sends = 0;
			foreach (kinds_seen[k]) kinds_seen[k] = 0;
		endfunction

		function void set_mode(logic [1:0] m);
			mode = m;
		endfunction

		function int unsigned pending();
			return awaited_sends.size();
		endfunction

		// Work out the results of one accepted input transaction.
		function void note_item(logic [1:0] kind, logic [IN_DATA_W-1:0] data);
			logic [31:0] now;
			logic [18:0] sig;
			logic [17:0] grp;
			logic [31:0] tf;
			logic [31:0] per;
			logic [31:0] elapsed;
			int unsigned i;
			int unsigned s;
			int unsigned g;
			int unsigned n;
			logic        okv;
			now = data[31:0];
			sig = data[50:32];
			grp = data[68:51];
			tf = data[100:69];
			kinds_seen[kind]++;
			case (kind)
				KIND_TICK: begin
					n = 0;
					for (i = 0; i < g_count; i++) begin
						// A nonzero custom period overrides the mode's period.
						if (g_custom[i] != 32'd0)
							per = g_custom[i];
						else if (mode == MODE_STANDARD)
							per = {16'd0, g_std[i]};
						else if (mode == MODE_STRESS)
							per = {16'd0, g_stress[i]};
						else
							per = {16'd0, g_smooth[i]};
						elapsed = now - g_sent[i];
						if (elapsed >= per) begin
							g_sent[i] = now;
							awaited_sends.push_back('{ok: 1'b1, due: 1'b1, grp: g_id[i],
								prio: g_prio[i], src: g_src[i], slot: 4'(i), last: 1'b0});
							n++;
						end
					end
					if (n == 0)
						awaited_sends.push_back('{ok: 1'b1, due: 1'b0, grp: '0, prio: '0,
							src: '0, slot: '0, last: 1'b1});
					else
						awaited_sends[awaited_sends.size() - 1].last = 1'b1;
				end
				KIND_ADD: begin
					okv = 1'b1;
					s = s_count;
					for (i = 0; i < s_count; i++)
						if (s == s_count && s_id[i] == sig) s = i;
					if (s == s_count && s_count >= MAX_S) begin
						okv = 1'b0;
					end else begin
						if (s == s_count) s_count++;
						s_id[s] = sig;
						s_grp[s] = grp;
						g = g_count;
						for (i = 0; i < g_count; i++)
							if (g == g_count && g_id[i] == grp) g = i;
						// With the group table full the signal stays stored but the add fails.
						if (g == g_count && g_count >= MAX_G) begin
							okv = 1'b0;
						end else begin
							if (g == g_count) begin
								g_id[g] = grp;
								g_std[g] = data[116:101];
								g_stress[g] = data[132:117];
								g_smooth[g] = data[148:133];
								g_prio[g] = data[151:149];
								g_src[g] = data[159:152];
								g_custom[g] = 32'd0;
								g_sent[g] = now;
								g_count++;
							end
							if (tf != 32'd0 && (g_custom[g] == 32'd0 || tf < g_custom[g]))
								g_custom[g] = tf;
						end
					end
					if (!okv) refusals++;
					awaited_sends.push_back('{ok: okv, due: 1'b0, grp: '0, prio: '0,
						src: '0, slot: '0, last: 1'b1});
				end
				default: begin
					if (kind == KIND_RESET) begin
						for (i = 0; i < g_count; i++) g_sent[i] = now;
					end else begin
						g_count = 0;
						s_count = 0;
					end
					awaited_sends.push_back('{ok: 1'b1, due: 1'b0, grp: '0, prio: '0,
						src: '0, slot: '0, last: 1'b1});
				end
			endcase
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$error("%s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		// Match one result transaction against the oldest outstanding expectation.
		function void check_send(logic [OUT_DATA_W-1:0] data, logic [1:0] user, logic last);
			send_t want;
			if (awaited_sends.size() == 0) begin
				errors++;
				$error("result transaction with none outstanding: data %0h user %0h last %0b",
					data, user, last);
				return;
			end
			want = awaited_sends.pop_front();
			checked++;
			if (want.due) group_sends++;
			compare("ok", 32'(want.ok), 32'(user[0]));
			compare("due", 32'(want.due), 32'(user[1]));
			compare("due_group", 32'(want.grp), 32'(data[17:0]));
			compare("due_priority", 32'(want.prio), 32'(data[20:18]));
			compare("due_source", 32'(want.src), 32'(data[28:21]));
			compare("due_slot", 32'(want.slot), 32'(data[32:29]));
			compare("last", 32'(want.last), 32'(last));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [1:0]            cfg_wdata = 2'd0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = 2'd0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	bit              steady = 1'b0;
	logic [31:0]     ms_now = 32'd0;
	sched_scoreboard board = new();

	periodic_message_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #6 clk = ~clk;

	// The receiver stalls at random unless a steady stretch is running.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 13);
	end

	// Both handshakes are observed at the rising edge.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) board.note_item(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready) board.check_send(m_tdata, m_tuser, m_tlast);
	end

	// Present one input transaction and hold it until it is taken.
	task automatic send_item(input logic [1:0] kind, input logic [IN_DATA_W-1:0] data);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 13) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tuser = kind;
		s_tdata = data;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_add(input logic [31:0] now, input logic [18:0] sig,
		input logic [17:0] grp, input logic [31:0] tf, input logic [15:0] std_p,
		input logic [15:0] stress_p, input logic [15:0] smooth_p, input logic [2:0] prio,
		input logic [7:0] src);
		send_item(KIND_ADD, {src, prio, smooth_p, stress_p, std_p, tf, grp, sig, now});
	endtask

	// Fields that a non-add item ignores still carry random bits.
	task automatic send_other(input logic [1:0] kind, input logic [31:0] now);
		send_item(kind, {$urandom, $urandom, $urandom, $urandom, now});
	endtask

	function automatic logic [15:0] pick_period();
		int unsigned c;
		c = $urandom_range(0, 9);
		if (c == 0) return 16'd0;
		if (c == 1) return 16'($urandom);
		return 16'($urandom_range(1, 80));
	endfunction

	task automatic send_random_add(input logic [18:0] sig, input logic [17:0] grp);
		logic [31:0] tf;
		int unsigned c;
		c = $urandom_range(0, 9);
		if (c < 5) tf = 32'd0;
		else if (c < 8) tf = $urandom_range(1, 60);
		else if (c == 8) tf = $urandom;
		else tf = 32'hFFFF_FFFF;
		send_add(ms_now, sig, grp, tf, pick_period(), pick_period(), pick_period(),
			3'($urandom), 8'($urandom));
	endtask

	// Hold the sender off until every expected result has been taken.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(input logic [1:0] m);
		drain_results();
		cfg_wdata = m;
		cfg_wen = 1'b1;
		@(negedge clk);
		cfg_wen = 1'b0;
		board.set_mode(m);
	endtask

	// One random phase under a given period mode, optionally filling both tables first.
	task automatic run_phase(input int unsigned count, input logic [1:0] m, input bit quiet,
		input bit fill, input logic [31:0] start_ms);
		int unsigned k;
		int unsigned pick;
		logic [18:0] sig_base;
		logic [17:0] grp_base;
		logic [18:0] sig;
		logic [17:0] grp;
		set_mode(m);
		steady = quiet;
		ms_now = start_ms;
		if (fill) begin
			sig_base = 19'($urandom_range(0, 32'h7FFC0));
			grp_base = 18'($urandom_range(0, 32'h3FFC0));
			send_other(KIND_CLEAR, ms_now);
			// More signals and groups than fit, so both full cases are reached.
			for (k = 0; k < 36; k++) begin
				if (k % 6 == 5) begin
					ms_now += $urandom_range(0, 30);
					send_other(KIND_TICK, ms_now);
				end
				send_random_add(sig_base + 19'(k), grp_base + 18'(k % 18));
			end
		end
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 5) drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if ($urandom_range(0, 19) == 0) ms_now = $urandom;
				else ms_now += $urandom_range(0, 40);
				send_other(KIND_TICK, ms_now);
			end else if (pick < 86) begin
				sig = ($urandom_range(0, 9) < 7) ? 19'($urandom_range(0, 23)) : 19'($urandom);
				grp = ($urandom_range(0, 3) < 3) ? 18'($urandom_range(0, 11)) : 18'($urandom);
				send_random_add(sig, grp);
			end else if (pick < 96) begin
				send_other(KIND_RESET, ms_now);
			end else begin
				send_other(KIND_CLEAR, ms_now);
			end
		end
		steady = 1'b0;
	endtask

	// Main sequence: reset, directed cases, random phases, then the verdict.
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_mode(MODE_STANDARD);

		// Empty tables: a tick, a clear and a timer reset each give a single idle result.
		send_other(KIND_TICK, 32'd0);
		send_other(KIND_CLEAR, 32'd0);
		send_other(KIND_RESET, 32'd0);
		// Field extremes, then updates of an existing group and signal.
		send_add(32'd100, 19'd0, 18'd0, 32'd0, 16'd10, 16'd20, 16'd30, 3'd0, 8'd0);
		send_add(32'd100, 19'h7FFFF, 18'h3FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			3'd7, 8'hFF);
		send_add(32'd101, 19'd5, 18'd0, 32'd25, 16'd1, 16'd2, 16'd3, 3'd5, 8'h5A);
		send_add(32'd102, 19'd6, 18'd0, 32'd40, 16'd4, 16'd5, 16'd6, 3'd2, 8'hA5);
		send_add(32'd103, 19'd5, 18'd0, 32'd0, 16'd7, 16'd8, 16'd9, 3'd1, 8'h11);
		// A zero standard period makes this group due on every tick.
		send_add(32'd104, 19'd7, 18'd3, 32'd0, 16'd0, 16'd50, 16'd60, 3'd3, 8'h33);
		send_other(KIND_TICK, 32'd110);
		send_other(KIND_TICK, 32'd125);
		send_other(KIND_RESET, 32'd200);
		send_other(KIND_TICK, 32'd200);
		// Time going backwards wraps to the largest elapsed time: every group is due.
		send_other(KIND_TICK, 32'd199);
		send_add(32'd210, 19'd8, 18'h20000, 32'd1, 16'd9, 16'd9, 16'd9, 3'd4, 8'h80);
		send_other(KIND_TICK, 32'd211);
		send_other(KIND_CLEAR, 32'd220);
		send_other(KIND_TICK, 32'd230);

		run_phase(14, MODE_SMOOTH, 1'b0, 1'b0, $urandom);
		run_phase(16, MODE_STRESS, 1'b1, 1'b0, 32'hFFFF_FFC0);
		run_phase(6, MODE_UNUSED, 1'b0, 1'b1, $urandom);
		run_phase(14, MODE_STANDARD, 1'b0, 1'b0, $urandom);

		drain_results();
		repeat (60) @(negedge clk);

		$display("Covered %0d ticks, %0d signal adds (%0d refused), %0d timer resets, %0d clears",
			board.kinds_seen[KIND_TICK], board.kinds_seen[KIND_ADD], board.refusals,
			board.kinds_seen[KIND_RESET], board.kinds_seen[KIND_CLEAR]);
		$display("under all four mode codes; %0d results checked, %0d of them group sends.",
			board.checked, board.group_sends);
		if (board.errors == 0)
			$display("periodic_message_scheduler regression: pass");
		else
			$display("periodic_message_scheduler regression: fail");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5000000;
		$display("periodic_message_scheduler regression: fail");
		$finish;
	end

endmodule
